// ===== src/cbo_pkg.sv =====
// Shared definitions for the caption bar overlay: bar geometry constants,
// font and caption tables, and the geometry struct passed between modules.
// No dependencies.
`default_nettype none

package cbo_pkg;

    // Field widths
    localparam int COORD_BITS  = 13;
    localparam int SAMPLE_BITS = 8;
    localparam int PLANE_BITS  = 2;
    localparam int MODE_BITS   = 2;
    localparam int CFG_IDX_BITS = 2;

    // Caption layout
    localparam int CAPTION_LEN  = 27;
    localparam int GLYPH_WIDTH  = 7;
    localparam int GLYPH_HEIGHT = 12;
    localparam int PAD_HORIZ    = 10;
    localparam int PAD_VERT     = 3;
    localparam int TEXT_PIX     = CAPTION_LEN * GLYPH_WIDTH;
    localparam int BAR_W        = TEXT_PIX + PAD_HORIZ * 2;
    localparam int BAR_H        = GLYPH_HEIGHT + PAD_VERT * 2;
    localparam int ROM_GLYPHS   = 18;
    localparam int ROM_ROWS     = 12;

    // Character index = (dx * RECIP_MUL) >> RECIP_SHIFT, exact for dx < TEXT_PIX
    localparam int RECIP_MUL   = 293;
    localparam int RECIP_SHIFT = 11;
    localparam int DX_BITS     = 8;
    localparam int CHAR_BITS   = 5;
    localparam int GLYPH_BITS  = 5;
    localparam int DY_BITS     = 4;
    localparam int BIT_BITS    = 3;

    // Sample values
    localparam logic [SAMPLE_BITS-1:0] TEXT_COLOR = 8'd220;
    localparam logic [SAMPLE_BITS-1:0] NEUTRAL    = 8'd128;

    // Reset values of the registers
    localparam logic [COORD_BITS-1:0] WIDTH_RESET  = 13'd1920;
    localparam logic [COORD_BITS-1:0] HEIGHT_RESET = 13'd1080;

    // Register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_CHROMA_MODE  = 2'd2,
        REG_UNUSED       = 2'd3
    } cfg_index_t;

    // Chroma modes
    typedef enum logic [MODE_BITS-1:0] {
        MODE_PLANAR_420 = 2'd0,
        MODE_NV12       = 2'd1,
        MODE_LUMA_ONLY  = 2'd2,
        MODE_PASS       = 2'd3
    } chroma_mode_t;

    // Plane codes
    localparam logic [PLANE_BITS-1:0] PLANE_Y = 2'd0;
    localparam logic [PLANE_BITS-1:0] PLANE_U = 2'd1;
    localparam logic [PLANE_BITS-1:0] PLANE_V = 2'd2;

    // Bar geometry derived from the frame registers
    typedef struct packed {
        logic                  enable;   // frame holds the bar, mode not pass
        chroma_mode_t          mode;
        logic [COORD_BITS-1:0] width;
        logic [COORD_BITS-1:0] height;
        logic [COORD_BITS-1:0] bar_x;
        logic [COORD_BITS-1:0] bar_y;
        logic [COORD_BITS-1:0] text_x;
        logic [COORD_BITS-1:0] text_y;
        logic [COORD_BITS-1:0] c_bar_x;  // chroma region bounds
        logic [COORD_BITS-1:0] c_bar_y;
        logic [COORD_BITS-1:0] c_width;
        logic [COORD_BITS-1:0] c_height;
    } geom_t;

    // Font: space - . E I L R S a c e l m o r s t y
    localparam logic [7:0] FONT_ROM [ROM_GLYPHS][ROM_ROWS] = '{
        '{8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
        '{8'h00,8'h00,8'h00,8'h00,8'h00,8'h78,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
        '{8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h30,8'h30,8'h00,8'h00},
        '{8'h00,8'h00,8'h7C,8'h40,8'h40,8'h78,8'h40,8'h40,8'h40,8'h7C,8'h00,8'h00},
        '{8'h00,8'h00,8'h7C,8'h10,8'h10,8'h10,8'h10,8'h10,8'h10,8'h7C,8'h00,8'h00},
        '{8'h00,8'h00,8'h40,8'h40,8'h40,8'h40,8'h40,8'h40,8'h40,8'h7C,8'h00,8'h00},
        '{8'h00,8'h00,8'h78,8'h44,8'h44,8'h78,8'h50,8'h48,8'h44,8'h44,8'h00,8'h00},
        '{8'h00,8'h00,8'h38,8'h44,8'h40,8'h38,8'h04,8'h04,8'h44,8'h38,8'h00,8'h00},
        '{8'h00,8'h00,8'h00,8'h00,8'h38,8'h04,8'h3C,8'h44,8'h44,8'h3C,8'h00,8'h00},
        '{8'h00,8'h00,8'h00,8'h00,8'h38,8'h44,8'h40,8'h40,8'h44,8'h38,8'h00,8'h00},
        '{8'h00,8'h00,8'h00,8'h00,8'h38,8'h44,8'h7C,8'h40,8'h40,8'h38,8'h00,8'h00},
        '{8'h00,8'h00,8'h30,8'h10,8'h10,8'h10,8'h10,8'h10,8'h10,8'h38,8'h00,8'h00},
        '{8'h00,8'h00,8'h00,8'h00,8'h6C,8'h54,8'h54,8'h54,8'h54,8'h54,8'h00,8'h00},
        '{8'h00,8'h00,8'h00,8'h00,8'h38,8'h44,8'h44,8'h44,8'h44,8'h38,8'h00,8'h00},
        '{8'h00,8'h00,8'h00,8'h00,8'h58,8'h60,8'h40,8'h40,8'h40,8'h40,8'h00,8'h00},
        '{8'h00,8'h00,8'h00,8'h00,8'h38,8'h40,8'h38,8'h04,8'h44,8'h38,8'h00,8'h00},
        '{8'h00,8'h00,8'h10,8'h10,8'h78,8'h10,8'h10,8'h10,8'h10,8'h0C,8'h00,8'h00},
        '{8'h00,8'h00,8'h00,8'h00,8'h44,8'h44,8'h44,8'h44,8'h3C,8'h04,8'h78,8'h00}
    };

    // Caption text as glyph numbers
    localparam logic [GLYPH_BITS-1:0] CAPTION_ROM [CAPTION_LEN] = '{
        5'd3, 5'd8, 5'd15, 5'd17, 5'd0, 5'd4, 5'd6, 5'd5, 5'd0,
        5'd7, 5'd16, 5'd14, 5'd10, 5'd8, 5'd12, 5'd0, 5'd1, 5'd0,
        5'd15, 5'd16, 5'd13, 5'd13, 5'd11, 5'd15, 5'd2, 5'd9, 5'd9
    };

endpackage

`default_nettype wire

// ===== src/caption_bar_overlay_unit.sv =====
// Caption bar overlay, top level: input register, sample logic, result register.
// Depends on cbo_pkg, cbo_cfg_regs and cbo_sample_proc.
//
// Stamps a 209x18 caption bar into the bottom-right corner of a video frame,
// one sample per transaction. Luma inside the bar is darkened by a right shift
// of 2 and caption pixels are forced to 220; chroma under the bar is set to 128
// (planar 4:2:0 or NV12 per chroma_mode). Throughput is one sample per clock
// while the output is not stalled; each accepted sample passes through the input
// register and then the result register around the combinational sample logic.
// Backpressure on the output holds the result register, and the input register
// too once it holds a sample. Write the frame registers only while no samples
// are in flight.
`default_nettype none

module caption_bar_overlay_unit (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // configuration channel
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [cbo_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [cbo_pkg::COORD_BITS-1:0]    cfg_data,
    // sample input channel
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [cbo_pkg::PLANE_BITS-1:0]    plane,
    input  wire logic [cbo_pkg::COORD_BITS-1:0]    column,
    input  wire logic [cbo_pkg::COORD_BITS-1:0]    row,
    input  wire logic [cbo_pkg::SAMPLE_BITS-1:0]   sample_in,
    // sample output channel
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [cbo_pkg::SAMPLE_BITS-1:0]        sample_out
);
    import cbo_pkg::*;

    geom_t                  geom;
    logic                   s1_valid_reg;
    logic [PLANE_BITS-1:0]  plane_reg;
    logic [COORD_BITS-1:0]  column_reg;
    logic [COORD_BITS-1:0]  row_reg;
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic                   out_valid_reg;
    logic [SAMPLE_BITS-1:0] result_reg;
    logic [SAMPLE_BITS-1:0] result_next;
    logic                   advance;

    cbo_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .geom      (geom)
    );

    cbo_sample_proc u_proc (
        .geom       (geom),
        .plane      (plane_reg),
        .column     (column_reg),
        .row        (row_reg),
        .sample_in  (sample_reg),
        .sample_out (result_next)
    );

    // Stage handshakes: result slot frees when empty or taken
    assign advance   = !out_valid_reg || out_ready;
    assign in_ready  = !s1_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign sample_out = result_reg;

    // Input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    // Input register payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            plane_reg  <= plane;
            column_reg <= column;
            row_reg    <= row;
            sample_reg <= sample_in;
        end
    end

    // Result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= s1_valid_reg;
    end

    // Result register payload
    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
            result_reg <= result_next;
    end

endmodule

`default_nettype wire

// ===== src/cbo_cfg_regs.sv =====
// Frame configuration registers and the bar geometry derived from them.
// Depends on cbo_pkg.
`default_nettype none

module cbo_cfg_regs (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [cbo_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic [cbo_pkg::COORD_BITS-1:0]   cfg_data,
    output cbo_pkg::geom_t                     geom
);
    import cbo_pkg::*;

    logic [COORD_BITS-1:0] width_reg;
    logic [COORD_BITS-1:0] height_reg;
    chroma_mode_t          mode_reg;

    assign cfg_ready = 1'b1;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            mode_reg   <= MODE_PLANAR_420;
        end
        else if (cfg_valid)
        begin
            case (cfg_index_t'(cfg_index))
                REG_FRAME_WIDTH:  width_reg  <= cfg_data;
                REG_FRAME_HEIGHT: height_reg <= cfg_data;
                REG_CHROMA_MODE:  mode_reg   <= chroma_mode_t'(cfg_data[MODE_BITS-1:0]);
                default:          ;
            endcase
        end
    end

    // Bar corner, text origin and chroma region
    always_comb
    begin
        geom.enable   = (width_reg >= COORD_BITS'(BAR_W)) &&
                        (height_reg >= COORD_BITS'(BAR_H)) && (mode_reg != MODE_PASS);
        geom.mode     = mode_reg;
        geom.width    = width_reg;
        geom.height   = height_reg;
        geom.bar_x    = width_reg - COORD_BITS'(BAR_W);
        geom.bar_y    = height_reg - COORD_BITS'(BAR_H);
        geom.text_x   = width_reg - COORD_BITS'(BAR_W - PAD_HORIZ);
        geom.text_y   = height_reg - COORD_BITS'(BAR_H - PAD_VERT);
        geom.c_bar_x  = geom.bar_x >> 1;
        geom.c_bar_y  = geom.bar_y >> 1;
        geom.c_width  = width_reg >> 1;
        geom.c_height = height_reg >> 1;
    end

endmodule

`default_nettype wire

// ===== src/cbo_sample_proc.sv =====
// Per-sample overlay logic: bar darkening, caption lookup, chroma neutralization.
// Purely combinational. Depends on cbo_pkg.
`default_nettype none

module cbo_sample_proc (
    input  wire cbo_pkg::geom_t                 geom,
    input  wire logic [cbo_pkg::PLANE_BITS-1:0]  plane,
    input  wire logic [cbo_pkg::COORD_BITS-1:0]  column,
    input  wire logic [cbo_pkg::COORD_BITS-1:0]  row,
    input  wire logic [cbo_pkg::SAMPLE_BITS-1:0] sample_in,
    output logic [cbo_pkg::SAMPLE_BITS-1:0]      sample_out
);
    import cbo_pkg::*;

    logic                  in_bar;
    logic [COORD_BITS-1:0] dx_full;
    logic [COORD_BITS-1:0] dy_full;
    logic                  in_text;
    logic [DX_BITS-1:0]    dx;
    logic [DX_BITS+8:0]    dx_scaled;
    logic [CHAR_BITS-1:0]  char_idx;
    logic [BIT_BITS-1:0]   bit_idx;
    logic [DY_BITS-1:0]    dy;
    logic [7:0]            glyph_bits;
    logic                  text_pixel;
    logic                  in_rows;
    logic [COORD_BITS-1:0] pair;
    logic                  chroma_hit;

    // Luma bar and caption cell position
    always_comb
    begin
        in_bar    = (column >= geom.bar_x) && (column < geom.width) &&
                    (row >= geom.bar_y) && (row < geom.height);
        dx_full   = column - geom.text_x;
        dy_full   = row - geom.text_y;
        in_text   = (column >= geom.text_x) && (dx_full < COORD_BITS'(TEXT_PIX)) &&
                    (row >= geom.text_y) && (dy_full < COORD_BITS'(GLYPH_HEIGHT));
        dx        = dx_full[DX_BITS-1:0];
        dy        = dy_full[DY_BITS-1:0];
        // divide by glyph width through a reciprocal multiply
        dx_scaled = (DX_BITS+9)'(dx) * (DX_BITS+9)'(RECIP_MUL);
        char_idx  = dx_scaled[RECIP_SHIFT +: CHAR_BITS];
        bit_idx   = BIT_BITS'(dx - DX_BITS'(char_idx) * DX_BITS'(GLYPH_WIDTH));
        glyph_bits = FONT_ROM[CAPTION_ROM[char_idx]][dy];
        text_pixel = in_text && glyph_bits[3'd7 - bit_idx];
    end

    // Chroma region
    always_comb
    begin
        in_rows    = (row >= geom.c_bar_y) && (row < geom.c_height);
        pair       = column >> 1;
        chroma_hit = 1'b0;
        case (geom.mode)
            MODE_PLANAR_420:
                chroma_hit = (plane == PLANE_U || plane == PLANE_V) && in_rows &&
                             (column >= geom.c_bar_x) && (column < geom.c_width);
            MODE_NV12:
                chroma_hit = (plane == PLANE_U) && in_rows &&
                             (pair >= geom.c_bar_x) && (pair < geom.c_width);
            default:
                chroma_hit = 1'b0;
        endcase
    end

    // Output select
    always_comb
    begin
        sample_out = sample_in;
        if (geom.enable)
        begin
            if (plane == PLANE_Y)
            begin
                if (in_bar)
                    sample_out = text_pixel ? TEXT_COLOR : (sample_in >> 2);
            end
            else if (chroma_hit)
            begin
                sample_out = NEUTRAL;
            end
        end
    end

endmodule

`default_nettype wire
